[sv/assert_macros.svh]
// Assertion macros for the pose integrator; included by ppdr_ctrl.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge, skipped while in reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[sv/ppdr_pkg.sv]
// Package for the planar pose integrator: constants, state codes, types.
// No dependencies.
package ppdr_pkg;
  localparam int CordicSteps = 16;
  localparam int PosFracBits = 16;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [21:0] HeadK = 22'd2799883;
  // divide by 1e6: add half, drop 6 bits, multiply by ceil(2^62 / 15625)
  localparam logic [18:0] RoundHalf = 19'd500000;
  localparam logic [23:0] RecipHi = 24'd8796093;   // reciprocal bits [48:25]
  localparam logic [24:0] RecipLo = 25'd745177;    // reciprocal bits [24:0]

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD1, ST_CORD, ST_MULA, ST_MULB, ST_SUM, ST_DIVS, ST_DIVX,
    ST_DIVY, ST_CORD2, ST_QUAT, ST_OUT
  } state_t;

  typedef struct packed {
    logic cord_start;  // init cordic with angle source
    logic cord_half;   // 0: heading<<16, 1: half heading
    logic cord_step;
    logic mul_a;
    logic mul_b;
    logic sum;
    logic div_start;
    logic div_sel_y;
    logic div_step;
    logic commit_x;
    logic commit_y;
    logic quat;
  } cmd_t;

  typedef struct packed {
    logic cord_done;
    logic div_done;
  } sts_t;

  function automatic logic signed [31:0] atan_val(input logic [4:0] i);
    logic signed [31:0] t;
    begin
      t = 32'sd0;
      case (i)
        5'd0: t = 32'sd536870912;  5'd1: t = 32'sd316933405;
        5'd2: t = 32'sd167458907;  5'd3: t = 32'sd85004756;
        5'd4: t = 32'sd42667331;   5'd5: t = 32'sd21354465;
        5'd6: t = 32'sd10679838;   5'd7: t = 32'sd5340245;
        5'd8: t = 32'sd2670163;    5'd9: t = 32'sd1335086;
        5'd10: t = 32'sd667544;    5'd11: t = 32'sd333772;
        5'd12: t = 32'sd166886;    5'd13: t = 32'sd83443;
        5'd14: t = 32'sd41721;     5'd15: t = 32'sd20860;
        5'd16: t = 32'sd10430;     5'd17: t = 32'sd5215;
        5'd18: t = 32'sd2607;      5'd19: t = 32'sd1303;
        5'd20: t = 32'sd651;       5'd21: t = 32'sd325;
        5'd22: t = 32'sd162;       5'd23: t = 32'sd81;
        default: t = 32'sd0;
      endcase
      return t;
    end
  endfunction
endpackage

[sv/ppdr_if.sv]
// Valid/ready channel interfaces for the pose integrator.
// Depends on nothing.
interface ppdr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] vel_x;
  logic [15:0] vel_y;
  logic [15:0] turn_rate;
  logic [19:0] elapsed_us;
  logic [31:0] set_x;
  logic [31:0] set_y;
  logic [15:0] set_heading;
  modport source (output valid, mode, vel_x, vel_y, turn_rate, elapsed_us,
                  set_x, set_y, set_heading, input ready);
  modport sink (input valid, mode, vel_x, vel_y, turn_rate, elapsed_us,
                set_x, set_y, set_heading, output ready);
endinterface

interface ppdr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [15:0] heading;
  logic [15:0] quat_z;
  logic [14:0] quat_w;
  modport source (output valid, pos_x, pos_y, heading, quat_z, quat_w,
                  input ready);
  modport sink (input valid, pos_x, pos_y, heading, quat_z, quat_w,
                output ready);
endinterface

[sv/ppdr_ctrl.sv]
// Sequencer of the pose integrator: walks CORDIC, multiply, divide steps.
// Depends on ppdr_pkg and assert_macros.svh.
module ppdr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic            in_mode,
  input  logic            in_dt_zero,
  input  logic            out_busy,
  input  ppdr_pkg::sts_t  sts,
  output ppdr_pkg::cmd_t  cmd,
  output logic            load,
  output logic            idle,
  output logic            out_set
);
  import ppdr_pkg::*;
  `include "assert_macros.svh"

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    load = 1'b0;
    out_set = 1'b0;
    idle = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          load = 1'b1;
          if (!in_mode && !in_dt_zero) state_nxt = ST_LOAD1;
        end
      end
      ST_LOAD1: begin
        cmd.cord_start = 1'b1;
        state_nxt = ST_CORD;
      end
      ST_CORD: begin
        cmd.cord_step = 1'b1;
        if (sts.cord_done) state_nxt = ST_MULA;
      end
      ST_MULA: begin
        cmd.mul_a = 1'b1;
        state_nxt = ST_MULB;
      end
      ST_MULB: begin
        cmd.mul_b = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        state_nxt = ST_DIVS;
      end
      // world velocities are registered now; start the x divide
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_DIVX;
      end
      ST_DIVX: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.commit_x = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel_y = 1'b1;
          cmd.div_step = 1'b0;
          state_nxt = ST_DIVY;
        end
      end
      ST_DIVY: begin
        cmd.div_step = 1'b1;
        cmd.div_sel_y = 1'b1;
        if (sts.div_done) begin
          cmd.commit_y = 1'b1;
          cmd.div_step = 1'b0;
          cmd.cord_start = 1'b1;
          cmd.cord_half = 1'b1;
          state_nxt = ST_CORD2;
        end
      end
      ST_CORD2: begin
        cmd.cord_step = 1'b1;
        if (sts.cord_done) state_nxt = ST_QUAT;
      end
      ST_QUAT: begin
        if (!out_busy) begin
          cmd.quat = 1'b1;
          out_set = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `ASSERT_IMP(a_load_idle, clk, rst_n, load, state_r == ST_IDLE)
  `ASSERT_IMP(a_set_free, clk, rst_n, out_set, !out_busy)
  `ASSERT_NXT(a_tick_go, clk, rst_n, load && !in_mode && !in_dt_zero, state_r == ST_LOAD1)
endmodule

[sv/ppdr_dp.sv]
// Datapath of the pose integrator: pose state, CORDIC, multiplier, divider.
// Depends on ppdr_pkg.
module ppdr_dp #(
  parameter int CORDIC_STEPS = ppdr_pkg::CordicSteps,
  parameter int POS_FRAC_BITS = ppdr_pkg::PosFracBits
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ppdr_pkg::cmd_t  cmd,
  input  logic            load,
  input  logic            in_mode,
  input  logic [15:0]     in_vel_x,
  input  logic [15:0]     in_vel_y,
  input  logic [15:0]     in_turn_rate,
  input  logic [19:0]     in_elapsed_us,
  input  logic [31:0]     in_set_x,
  input  logic [31:0]     in_set_y,
  input  logic [15:0]     in_set_heading,
  output ppdr_pkg::sts_t  sts,
  output logic [31:0]     pos_x,
  output logic [31:0]     pos_y,
  output logic [15:0]     heading,
  output logic [15:0]     quat_z,
  output logic [14:0]     quat_w
);
  import ppdr_pkg::*;

  localparam int Sh = 38 - POS_FRAC_BITS;
  localparam int AccBits = 97;

  logic signed [31:0] px_r, py_r;
  logic [15:0] ph_r;
  logic signed [15:0] vx_r, vy_r, rate_r;
  logic [19:0] dt_r;

  // CORDIC
  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] cz_r;
  logic flip_r;
  logic [4:0] it_r;
  logic [31:0] ang;
  logic [15:0] ph_new;
  logic signed [33:0] xs, ys;
  logic signed [31:0] at;

  // products
  logic signed [49:0] p_vxc_r, p_vys_r, p_vxs_r, p_vyc_r;
  logic signed [63:0] wx_r, wy_r;
  logic signed [63:0] dh_r;
  logic signed [36:0] rdt;
  logic signed [59:0] dhk;

  // divide by 1e6: t = (|w*dt| + 5e5) >> 6, then t * ceil(2^62/15625) >> 62,
  // four 24x25 partial products, one per cycle
  logic [47:0] td_r;
  logic [AccBits-1:0] acc_r;
  logic [2:0] dcnt_r;
  logic dneg_r;
  logic [23:0] pa;
  logic [24:0] pb;
  logic [48:0] pp;
  logic [6:0] pp_amt;
  logic [AccBits-1:0] pp_sh;
  logic [34:0] dq;
  logic signed [33:0] wsel;
  logic signed [64:0] num;
  logic [63:0] mag;
  logic signed [65:0] qs;
  logic signed [65:0] newp;
  logic signed [31:0] sat_v;
  logic signed [33:0] qzs, qws;

  always_comb begin
    // half-heading pass starts on the edge that commits the new heading
    ph_new = ph_r + dh_r[55:40];
    if (cmd.cord_half) ang = {ph_new[15], ph_new, 15'd0};
    else ang = {ph_r, 16'd0};
    xs = cx_r >>> it_r;
    ys = cy_r >>> it_r;
    at = atan_val(it_r);
  end

  assign sts.cord_done = (it_r == 5'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
      ph_r <= '0;
    end else begin
      if (load && in_mode) begin
        px_r <= in_set_x;
        py_r <= in_set_y;
        ph_r <= in_set_heading;
      end
      if (cmd.commit_x) px_r <= sat_v;
      if (cmd.commit_y) begin
        py_r <= sat_v;
        ph_r <= ph_r + dh_r[55:40];
      end
    end
  end

  always_comb begin
    rdt = rate_r * $signed({1'b0, dt_r});
    dhk = $signed(dh_r[36:0]) * $signed({1'b0, HeadK});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vx_r <= in_vel_x;
      vy_r <= in_vel_y;
      rate_r <= in_turn_rate;
      dt_r <= in_elapsed_us;
    end
    if (cmd.cord_start) begin
      cx_r <= CordicGain;
      cy_r <= '0;
      it_r <= '0;
      if ((ang + 32'h4000_0000) >= 32'h8000_0000) begin
        cz_r <= 33'(signed'(ang + 32'h8000_0000));
        flip_r <= 1'b1;
      end else begin
        cz_r <= 33'(signed'(ang));
        flip_r <= 1'b0;
      end
    end else if (cmd.cord_step) begin
      it_r <= it_r + 5'd1;
      if (!cz_r[32]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - 33'(at);
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + 33'(at);
      end
      if (sts.cord_done && flip_r) begin
        cx_r <= -(cx_r + ((!cz_r[32]) ? -ys : ys));
        cy_r <= -(cy_r + ((!cz_r[32]) ? xs : -xs));
      end
    end
    if (cmd.mul_a) begin
      p_vxc_r <= 50'(vx_r) * 50'(cx_r);
      p_vys_r <= 50'(vy_r) * 50'(cy_r);
    end
    if (cmd.mul_b) begin
      p_vxs_r <= 50'(vx_r) * 50'(cy_r);
      p_vyc_r <= 50'(vy_r) * 50'(cx_r);
      dh_r <= 64'(rdt);
    end
    if (cmd.sum) begin
      wx_r <= 64'((p_vxc_r - p_vys_r) >>> Sh);
      wy_r <= 64'((p_vxs_r + p_vyc_r) >>> Sh);
      dh_r <= 64'(dhk) + (64'sd1 <<< 39);
    end
  end

  // dividend = w * dt as magnitude and sign; partial product select
  always_comb begin
    wsel = cmd.div_sel_y ? wy_r[33:0] : wx_r[33:0];
    num = wsel * $signed({1'b0, dt_r});
    mag = num[64] ? 64'(-num) : 64'(num);
    case (dcnt_r)
      3'd0: begin
        pa = td_r[23:0];
        pb = RecipLo;
        pp_amt = 7'd0;
      end
      3'd1: begin
        pa = td_r[23:0];
        pb = {1'b0, RecipHi};
        pp_amt = 7'd25;
      end
      3'd2: begin
        pa = td_r[47:24];
        pb = RecipLo;
        pp_amt = 7'd24;
      end
      default: begin
        pa = td_r[47:24];
        pb = {1'b0, RecipHi};
        pp_amt = 7'd49;
      end
    endcase
    pp = pa * pb;
    pp_sh = {48'd0, pp} << pp_amt;
    dq = acc_r[96:62];
    qs = 66'(dq);
    newp = 66'(cmd.commit_y ? py_r : px_r) + (dneg_r ? -qs : qs);
    if (newp > 66'sd2147483647) sat_v = 32'h7fff_ffff;
    else if (newp < -66'sd2147483648) sat_v = 32'h8000_0000;
    else sat_v = newp[31:0];
  end

  assign sts.div_done = (dcnt_r == 3'd4);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      td_r <= 48'((mag + 64'(RoundHalf)) >> 6);
      dneg_r <= num[64];
      acc_r <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step && !sts.div_done) begin
      dcnt_r <= dcnt_r + 3'd1;
      acc_r <= acc_r + pp_sh;
    end
  end

  always_comb begin
    qzs = (cy_r + 34'sd16384) >>> 15;
    qws = (cx_r + 34'sd16384) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (cmd.quat) begin
      pos_x <= px_r;
      pos_y <= py_r;
      heading <= ph_r;
      if (qzs > 34'sd32767) quat_z <= 16'h7fff;
      else if (qzs < -34'sd32768) quat_z <= 16'h8000;
      else quat_z <= qzs[15:0];
      if (qws > 34'sd32767) quat_w <= 15'h7fff;
      else if (qws < 0) quat_w <= '0;
      else quat_w <= qws[14:0];
    end
  end
endmodule

[sv/planar_pose_dead_reckoning_core.sv]
// Planar pose dead-reckoning integrator. A tick (mode 0, elapsed_us nonzero)
// rotates the body velocity by the stored heading with a shared iterative
// CORDIC (one rotation per cycle), scales it by the time step and divides
// by 1e6 with a reciprocal multiply (four partial products per axis),
// saturates the Q16.16 position, advances the wrapping binary heading and
// runs the CORDIC again on the half heading for the yaw quaternion. A tick
// that finishes while the previous result is still not taken waits in QUAT;
// the next item is taken once the block is back in idle. One item is in
// work at a time. A pose load or a zero-time tick is taken in idle and
// yields no transfer. The result sits in an output register so the next
// item can be accepted while it waits.
// Depends on ppdr_pkg, ppdr_if, ppdr_ctrl, ppdr_dp.
module planar_pose_dead_reckoning_core #(
  parameter int CORDIC_STEPS = ppdr_pkg::CordicSteps,
  parameter int POS_FRAC_BITS = ppdr_pkg::PosFracBits
) (
  input logic clk,
  input logic rst_n,
  ppdr_in_if.sink    in_ch,
  ppdr_out_if.source out_ch
);
  import ppdr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic load, idle, out_set, in_fire, out_valid_r;

  assign in_ch.ready = idle;
  assign in_fire = in_ch.valid && idle;
  assign out_ch.valid = out_valid_r;

  // output holds until the transfer; a new result waits in QUAT state
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_set) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  ppdr_ctrl u_ctrl (
    .clk, .rst_n, .in_fire,
    .in_mode(in_ch.mode),
    .in_dt_zero(in_ch.elapsed_us == '0),
    .out_busy(out_valid_r && !out_ch.ready),
    .sts, .cmd, .load, .idle, .out_set
  );

  ppdr_dp #(.CORDIC_STEPS(CORDIC_STEPS), .POS_FRAC_BITS(POS_FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .load,
    .in_mode(in_ch.mode),
    .in_vel_x(in_ch.vel_x),
    .in_vel_y(in_ch.vel_y),
    .in_turn_rate(in_ch.turn_rate),
    .in_elapsed_us(in_ch.elapsed_us),
    .in_set_x(in_ch.set_x),
    .in_set_y(in_ch.set_y),
    .in_set_heading(in_ch.set_heading),
    .sts,
    .pos_x(out_ch.pos_x),
    .pos_y(out_ch.pos_y),
    .heading(out_ch.heading),
    .quat_z(out_ch.quat_z),
    .quat_w(out_ch.quat_w)
  );
endmodule
